>>> hw/rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants, tables and types for the signed integer to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int MAX_DIGITS  = 10;
   localparam int VALUE_W     = 32;
   localparam int MAG_W       = 32;
   localparam int CHAR_W      = 8;
   localparam int WIDE_W      = 64;
   localparam int RADIX       = 10;
   localparam int DIGIT_W     = $clog2(RADIX);
   localparam int POS_W       = $clog2(MAX_DIGITS);
   localparam int NDIG_W      = $clog2(MAX_DIGITS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

   // Row k holds d * 10**k for every digit d.
   typedef logic [MAX_DIGITS-1:0][RADIX-1:0][WIDE_W-1:0] weight_tab_type;

   function automatic logic [WIDE_W-1:0] pow10(int n);
      logic [WIDE_W-1:0] p;
      p = WIDE_W'(1);
      for (int i = 0; i < n; i++) begin
         p = p * WIDE_W'(RADIX);
      end
      return p;
   endfunction

   function automatic weight_tab_type weight_table();
      weight_tab_type t;
      for (int k = 0; k < MAX_DIGITS; k++) begin
         for (int d = 0; d < RADIX; d++) begin
            t[k][d] = WIDE_W'(d) * pow10(k);
         end
      end
      return t;
   endfunction

   localparam weight_tab_type    WEIGHT    = weight_table();
   localparam logic [WIDE_W-1:0] MAG_LIMIT = pow10(MAX_DIGITS) - WIDE_W'(1);

   typedef struct packed {
      logic              neg;
      logic [MAG_W-1:0]  mag;
      logic [NDIG_W-1:0] ndig;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SIGN,
      ST_DIGIT
   } state_type;

endpackage

>>> hw/rtl/itoa_front.sv
// ----------------------------------------------------------------------------
// itoa_front
// Takes a request, splits it into sign and magnitude, clamps the magnitude
// to the digit capacity and counts its decimal digits.
// ----------------------------------------------------------------------------
module itoa_front
   import itoa_pkg::*;
(
   input  logic                      start,
   input  logic                      busy,
   input  logic signed [VALUE_W-1:0] value,
   output push_type                  push
);

   logic                  neg;
   logic [MAG_W-1:0]      mag_abs;
   logic [MAG_W-1:0]      mag_sat;
   logic [MAX_DIGITS-1:0] big;

   assign neg     = value[VALUE_W-1];
   assign mag_abs = neg ? (MAG_W'(0) - MAG_W'($unsigned(value))) : MAG_W'($unsigned(value));

   always_comb begin
      if (WIDE_W'(mag_abs) > MAG_LIMIT) begin
         mag_sat = MAG_W'(MAG_LIMIT);
      end else begin
         mag_sat = mag_abs;
      end
   end

   // Every value has at least one digit; each power of ten reached adds one.
   always_comb begin
      big[0] = 1'b1;
      for (int k = 1; k < MAX_DIGITS; k++) begin
         big[k] = WIDE_W'(mag_sat) >= WEIGHT[k][1];
      end
   end

   assign push.valid     = start && !busy;
   assign push.item.neg  = neg;
   assign push.item.mag  = mag_sat;
   assign push.item.ndig = NDIG_W'($countones(big));

endmodule

>>> hw/rtl/itoa_queue.sv
// ----------------------------------------------------------------------------
// itoa_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module itoa_queue
   import itoa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   input  logic         pop,
   output item_type     head,
   output q_status_type status
);

   item_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;

   assign wr_ptr_in = push.valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + QCNT_W'(push.valid) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.item;
      end
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign status.empty = count_ff == QCNT_W'(0);
   assign status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);

endmodule

>>> hw/rtl/itoa_back.sv
// ----------------------------------------------------------------------------
// itoa_back
// Emits a minus for negatives, then one decimal digit per cycle, most
// significant first, by subtracting multiples of the current power of ten.
// ----------------------------------------------------------------------------
module itoa_back
   import itoa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  item_type           head,
   input  q_status_type       qstat,
   output logic               pop,
   output logic               rsp_strobe,
   output logic [CHAR_W-1:0]  rsp_char_out,
   output logic               rsp_last
);

   state_type              state_ff, state_in;
   logic [MAG_W-1:0]       mag_ff, mag_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic                   strobe_ff, strobe_in;
   logic [CHAR_W-1:0]      char_ff, char_in;
   logic                   last_ff, last_in;

   logic [RADIX-1:0][WIDE_W-1:0] row;
   logic [DIGIT_W-1:0]           digit;
   logic [WIDE_W-1:0]            sub;

   // The digit is the largest d whose weight still fits in the remainder.
   always_comb begin
      row   = WEIGHT[pos_ff];
      digit = '0;
      for (int d = 1; d < RADIX; d++) begin
         if (WIDE_W'(mag_ff) >= row[d]) begin
            digit = DIGIT_W'(d);
         end
      end
      sub = row[digit];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               state_in = head.neg ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            if (pos_ff == POS_W'(0)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      mag_in    = mag_ff;
      pos_in    = pos_ff;
      strobe_in = 1'b0;
      char_in   = CH_ZERO;
      last_in   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop    = 1'b1;
               mag_in = head.mag;
               pos_in = POS_W'(head.ndig - NDIG_W'(1));
            end
         end
         ST_SIGN: begin
            strobe_in = 1'b1;
            char_in   = CH_MINUS;
         end
         ST_DIGIT: begin
            strobe_in = 1'b1;
            char_in   = CH_ZERO + CHAR_W'(digit);
            last_in   = pos_ff == POS_W'(0);
            mag_in    = mag_ff - MAG_W'(sub);
            pos_in    = pos_ff - POS_W'(1);
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      pos_ff  <= pos_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_char_out = char_ff;
   assign rsp_last     = last_ff;

endmodule

>>> hw/rtl/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per response, with the final character flagged by rsp_last.
// ----------------------------------------------------------------------------
// A request is written into the queue, popped by the back end in its idle
// state, and its characters are registered before they appear. Throughput:
// one character per cycle while a number is converted; between numbers the
// back end passes through its idle state to load its next entry. A two-entry
// queue lets requests be taken while a conversion is running; busy is high
// only when that queue is full. Responses cannot be stalled. Synchronous
// reset empties the queue and idles the back end.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top
   import itoa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_strobe,
   output logic [CHAR_W-1:0]         rsp_char_out,
   output logic                      rsp_last
);

   push_type     push;
   item_type     head;
   q_status_type qstat;
   logic         pop;

   assign busy = qstat.full;

   itoa_front u_front (
      .start (start),
      .busy  (busy),
      .value (req_value),
      .push  (push)
   );

   itoa_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (qstat)
   );

   itoa_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .qstat        (qstat),
      .pop          (pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

   // A taken request always leaves the queue non-empty, even with a pop.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !qstat.empty)
      else $error("queue empty after a request was taken");

   // The sign is never the final character of a number.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_char_out == CH_MINUS |-> !rsp_last)
      else $error("minus sign flagged as last character");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_char_out == CH_MINUS ||
                     (rsp_char_out >= CH_ZERO && rsp_char_out <= CH_NINE))
      else $error("character outside sign and digit codes");

   // The back end passes through its idle state to load after each number.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("character emitted right after a final character");

endmodule
